[rtl/mtrd_pkg.sv]
`timescale 1ns / 1ps
package mtrd_pkg;
  localparam int unsigned StateWords  = 624;
  localparam int unsigned TwistOffset = 397;
  localparam int unsigned IdxW        = 10;

  localparam logic [31:0] TwistXor    = 32'h9908b0df;
  localparam logic [31:0] HighBit     = 32'h80000000;
  localparam logic [31:0] LowBits     = 32'h7fffffff;
  localparam logic [31:0] InitMult    = 32'd1812433253;
  localparam logic [31:0] DefaultSeed = 32'd5489;
  localparam logic [31:0] TemperB     = 32'h9d2c5680;
  localparam logic [31:0] TemperC     = 32'hefc60000;

  localparam logic [1:0] RegSeed      = 2'd0;
  localparam logic [1:0] RegRangeLow  = 2'd1;
  localparam logic [1:0] RegRangeHigh = 2'd2;

  typedef enum logic [2:0] {
    OpNone   = 3'd0,
    OpSeed   = 3'd1,
    OpTwist  = 3'd2,
    OpDraw   = 3'd3,
    OpDivide = 3'd4
  } op_e;

  typedef struct packed {
    op_e op;
    logic start;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } status_t;

  function automatic logic [31:0] temper(input logic [31:0] w_in);
    logic [31:0] w;
    w = w_in;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & TemperB);
    w = w ^ ((w << 15) & TemperC);
    w = w ^ (w >> 18);
    return w;
  endfunction
endpackage

[rtl/mtrd_datapath.sv]
`timescale 1ns / 1ps
module mtrd_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mtrd_pkg::cmd_t       cmd_i,
  output mtrd_pkg::status_t    status_o,
  input  logic [31:0]          seed_i,
  input  logic [31:0]          range_low_i,
  input  logic [31:0]          range_high_i,
  output logic [31:0]          value_o,
  output logic [31:0]          raw_word_o
);
  // Seeding: per word, a multiply step then a write step. Twist: per word, three reads then a write.
  logic [31:0] mem_q [mtrd_pkg::StateWords];
  logic [31:0] rdata_q;
  logic        we;
  logic [mtrd_pkg::IdxW-1:0] waddr, raddr;
  logic [31:0] wdata;

  logic [mtrd_pkg::IdxW-1:0] pos_q, pos_d;
  logic [2:0]  ph_q, ph_d;
  logic        busy_q, busy_d, done_q, done_d;
  mtrd_pkg::op_e op_q, op_d;
  logic [31:0] a_q, a_d, b_q, b_d, prod_q, prod_d;
  logic [31:0] raw_q, raw_d, val_q, val_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, span_q, span_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] trial;
  logic [31:0] span_c, joined;
  logic [mtrd_pkg::IdxW-1:0] nxt, far;
  localparam logic [mtrd_pkg::IdxW-1:0] Last = mtrd_pkg::IdxW'(mtrd_pkg::StateWords - 1);
  localparam logic [mtrd_pkg::IdxW-1:0] Off  = mtrd_pkg::IdxW'(mtrd_pkg::TwistOffset);
  localparam logic [mtrd_pkg::IdxW-1:0] Wrap = mtrd_pkg::IdxW'(mtrd_pkg::StateWords
                                                 - mtrd_pkg::TwistOffset);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign nxt = (pos_q == Last) ? '0 : pos_q + 1'b1;
  assign far = (pos_q >= Wrap) ? pos_q - Wrap : pos_q + Off;
  assign joined = (a_q & mtrd_pkg::HighBit) | (b_q & mtrd_pkg::LowBits);
  assign span_c = range_high_i - range_low_i + 32'd1;
  assign trial = {rem_q, quo_q[31]} - {1'b0, span_q};

  always_comb begin
    pos_d = pos_q; ph_d = ph_q; busy_d = busy_q; done_d = 1'b0; op_d = op_q;
    a_d = a_q; b_d = b_q; prod_d = prod_q; raw_d = raw_q; val_d = val_q;
    rem_d = rem_q; quo_d = quo_q; span_d = span_q; cnt_d = cnt_q;
    we = 1'b0; waddr = pos_q; raddr = pos_q; wdata = a_q;
    if (cmd_i.start) begin
      op_d = cmd_i.op; busy_d = 1'b1; ph_d = '0;
      unique case (cmd_i.op)
        mtrd_pkg::OpSeed: begin
          pos_d = '0; we = 1'b1; waddr = '0; wdata = seed_i; a_d = seed_i;
          pos_d = 10'd1;
        end
        mtrd_pkg::OpTwist: pos_d = '0;
        mtrd_pkg::OpDraw: ph_d = '0;
        mtrd_pkg::OpDivide: begin
          span_d = span_c; rem_d = '0; quo_d = raw_q; cnt_d = '0;
        end
        default: busy_d = 1'b0;
      endcase
    end else if (busy_q) begin
      unique case (op_q)
        mtrd_pkg::OpSeed: begin
          if (ph_q == 3'd0) begin
            prod_d = mtrd_pkg::InitMult * (a_q ^ (a_q >> 30));
            ph_d = 3'd1;
          end else begin
            wdata = prod_q + 32'(pos_q);
            we = 1'b1; a_d = wdata; ph_d = 3'd0;
            if (pos_q == Last) begin
              busy_d = 1'b0; done_d = 1'b1; pos_d = '0;
            end else begin
              pos_d = pos_q + 1'b1;
            end
          end
        end
        mtrd_pkg::OpTwist: begin
          unique case (ph_q)
            3'd0: begin raddr = pos_q; ph_d = 3'd1; end
            3'd1: begin raddr = nxt; a_d = rdata_q; ph_d = 3'd2; end
            3'd2: begin raddr = far; b_d = rdata_q; ph_d = 3'd3; end
            default: begin
              we = 1'b1;
              wdata = rdata_q ^ (joined >> 1) ^ (joined[0] ? mtrd_pkg::TwistXor : '0);
              ph_d = 3'd0;
              if (pos_q == Last) begin
                busy_d = 1'b0; done_d = 1'b1; pos_d = '0;
              end else begin
                pos_d = pos_q + 1'b1;
              end
            end
          endcase
        end
        mtrd_pkg::OpDraw: begin
          if (ph_q == 3'd0) begin
            raddr = pos_q; ph_d = 3'd1;
          end else begin
            raw_d = mtrd_pkg::temper(rdata_q);
            pos_d = (pos_q == Last) ? '0 : pos_q + 1'b1;
            busy_d = 1'b0; done_d = 1'b1;
          end
        end
        mtrd_pkg::OpDivide: begin
          if (span_q == '0) begin
            val_d = raw_q; busy_d = 1'b0; done_d = 1'b1;
          end else begin
            quo_d = {quo_q[30:0], 1'b0};
            if (!trial[32]) rem_d = trial[31:0];
            else rem_d = {rem_q[30:0], quo_q[31]};
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == 6'd31) begin
              val_d = range_low_i + rem_d; busy_d = 1'b0; done_d = 1'b1;
            end
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; op_q <= mtrd_pkg::OpNone;
      pos_q <= '0; ph_q <= '0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; op_q <= op_d;
      pos_q <= pos_d; ph_q <= ph_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; prod_q <= prod_d; raw_q <= raw_d; val_q <= val_d;
    rem_q <= rem_d; quo_q <= quo_d; span_q <= span_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign value_o    = val_q;
  assign raw_word_o = raw_q;
endmodule

[rtl/mtrd_ctrl.sv]
`timescale 1ns / 1ps
module mtrd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              draw_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              reseed_i,
  input  logic              pos_wrap_i,
  output mtrd_pkg::cmd_t    cmd_o,
  input  mtrd_pkg::status_t status_i
);
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StSeed  = 7'b0000010,
    StTwist = 7'b0000100,
    StDraw  = 7'b0001000,
    StDiv   = 7'b0010000,
    StOut   = 7'b0100000,
    StLaunch = 7'b1000000
  } state_e;

  state_e st_q, st_d;
  logic need_seed_q, need_seed_d, need_twist_q, need_twist_d;
  logic acc;

  assign in_stall_o  = (st_q != StIdle);
  assign out_valid_o = (st_q == StOut);
  assign acc = in_valid_i && (st_q == StIdle) && draw_i;

  always_comb begin
    st_d = st_q; need_seed_d = need_seed_q || reseed_i; need_twist_d = need_twist_q;
    cmd_o.start = 1'b0; cmd_o.op = mtrd_pkg::OpNone;
    unique case (st_q)
      StIdle: if (acc) st_d = StLaunch;
      StLaunch: begin
        cmd_o.start = 1'b1;
        if (need_seed_q) begin
          cmd_o.op = mtrd_pkg::OpSeed; st_d = StSeed; need_seed_d = 1'b0;
        end else if (need_twist_q) begin
          cmd_o.op = mtrd_pkg::OpTwist; st_d = StTwist;
        end else begin
          cmd_o.op = mtrd_pkg::OpDraw; st_d = StDraw;
        end
      end
      StSeed: if (status_i.done) begin
        need_twist_d = 1'b1; st_d = StLaunch;
      end
      StTwist: if (status_i.done) begin
        need_twist_d = 1'b0; st_d = StLaunch;
      end
      StDraw: if (status_i.done) begin
        if (pos_wrap_i) need_twist_d = 1'b1;
        cmd_o.start = 1'b1; cmd_o.op = mtrd_pkg::OpDivide; st_d = StDiv;
      end
      StDiv: if (status_i.done) st_d = StOut;
      StOut: if (!out_stall_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; need_seed_q <= 1'b1; need_twist_q <= 1'b1;
    end else begin
      st_q <= st_d; need_seed_q <= need_seed_d; need_twist_q <= need_twist_d;
    end
  end
endmodule

[rtl/mersenne_twister_range_draw_unit.sv]
`timescale 1ns / 1ps
// MT19937 draw unit with range reduction.
// Input channel: in_valid_i/in_stall_o with draw_i; a beat with draw_i low
// is taken and dropped. Output channel: out_valid_o/out_stall_i carrying
// value_o and raw_word_o, one beat per draw.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 seed, 1 range_low, 2 range_high); the user writes only while the
// unit is idle, which the unit itself does not enforce.
// Sequence: a draw reads and tempers the state word, forms the bit-serial
// remainder (one quotient bit a cycle; skipped for the full range), then
// presents it. The first draw after reset or a seed write first seeds the
// state (a registered multiply, then a write, per word); after every 624
// draws the next first twists it (3 reads and a write a word, 1 read port).
// One draw is in flight at a time; the input stalls until the result beat
// is taken. A stalled result holds value_o and raw_word_o.
// Reset: seed 5489, full range; state RAM is rebuilt on the first draw.
module mersenne_twister_range_draw_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        draw_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  output logic [31:0] raw_word_o
);
  logic [31:0] seed_q, low_q, high_q;
  logic reseed;
  mtrd_pkg::cmd_t    cmd;
  mtrd_pkg::status_t status;
  logic [9:0] draws_q;
  logic wrap;

  assign reseed = cfg_we_i && (cfg_idx_i == mtrd_pkg::RegSeed);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= mtrd_pkg::DefaultSeed; low_q <= '0; high_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mtrd_pkg::RegSeed:      seed_q <= cfg_data_i;
        mtrd_pkg::RegRangeLow:  low_q  <= cfg_data_i;
        mtrd_pkg::RegRangeHigh: high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // count draws since the last twist
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draws_q <= '0;
    end else if (cmd.start && cmd.op == mtrd_pkg::OpTwist) begin
      draws_q <= '0;
    end else if (cmd.start && cmd.op == mtrd_pkg::OpDivide) begin
      draws_q <= draws_q + 1'b1;
    end
  end
  assign wrap = (draws_q == 10'(mtrd_pkg::StateWords - 1));

  mtrd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .draw_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .reseed_i(reseed), .pos_wrap_i(wrap), .cmd_o(cmd), .status_i(status)
  );

  mtrd_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .seed_i(seed_q),
    .range_low_i(low_q), .range_high_i(high_q), .value_o, .raw_word_o
  );

`ifndef SYNTH
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o)) else $error("ready while result pending");
  a_full_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && low_q == '0 && high_q == '1) |-> value_o == raw_word_o)
    else $error("full span must pass raw word");
  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && high_q >= low_q) |-> (value_o >= low_q && value_o <= high_q))
    else $error("value out of range");
`endif
endmodule
